/* design/ddft_pkg.sv */
// Package for the direct DFT block: field widths, fixed-point constants
// and the Q1.15 cosine table. No dependencies.
package ddft_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 40;
  localparam int BIN_W      = 6;
  localparam int FRAC_W     = 15;
  localparam int ROM_SIZE   = 64;
  localparam int ROM_W      = 6;
  localparam int POINTS_DEF = 64;

  // Quarter-turn offset that turns a cosine lookup into a sine lookup.
  localparam logic [ROM_W-1:0] SIN_OFFSET = ROM_W'(ROM_SIZE - ROM_SIZE / 4);

  // round(32767 * cos(2*pi*m/64)), m = 0 .. 63.
  localparam logic signed [SAMPLE_W-1:0] COS_TABLE [ROM_SIZE] = '{
    16'sd32767, 16'sd32609, 16'sd32137, 16'sd31356,
    16'sd30273, 16'sd28898, 16'sd27245, 16'sd25329,
    16'sd23170, 16'sd20787, 16'sd18204, 16'sd15446,
    16'sd12539, 16'sd9512,  16'sd6393,  16'sd3212,
    16'sd0,     -16'sd3212, -16'sd6393, -16'sd9512,
    -16'sd12539, -16'sd15446, -16'sd18204, -16'sd20787,
    -16'sd23170, -16'sd25329, -16'sd27245, -16'sd28898,
    -16'sd30273, -16'sd31356, -16'sd32137, -16'sd32609,
    -16'sd32767, -16'sd32609, -16'sd32137, -16'sd31356,
    -16'sd30273, -16'sd28898, -16'sd27245, -16'sd25329,
    -16'sd23170, -16'sd20787, -16'sd18204, -16'sd15446,
    -16'sd12539, -16'sd9512, -16'sd6393, -16'sd3212,
    16'sd0,     16'sd3212,  16'sd6393,  16'sd9512,
    16'sd12539, 16'sd15446, 16'sd18204, 16'sd20787,
    16'sd23170, 16'sd25329, 16'sd27245, 16'sd28898,
    16'sd30273, 16'sd31356, 16'sd32137, 16'sd32609
  };

endpackage

/* design/ddft_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ddft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/direct_dft_block.sv */
// Top level of the direct DFT block: sequencer, shared multiply-accumulate
// unit and output scaling. Depends on ddft_pkg and ddft_ram.
//
// The block collects POINTS samples into a sample RAM, one per input transfer,
// and then computes the DFT bin by bin with one cosine and one sine
// multiplier feeding two 40-bit accumulators. Each bin is one accumulation
// pass over the sample RAM followed by pipeline drain and scaling, after which
// the result is held until the output transfer; the input is stalled from the
// last sample of a block until the final bin has been transferred. A block
// therefore costs POINTS load transfers plus a single multiply-accumulate pass
// over the sample RAM for every bin.
module direct_dft_block #(
  parameter int POINTS = ddft_pkg::POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ddft_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ddft_pkg::BIN_W-1:0]          out_bin_index,
  output logic signed [ddft_pkg::SAMPLE_W-1:0] out_real_part,
  output logic signed [ddft_pkg::SAMPLE_W-1:0] out_imag_part,
  output logic                                out_last_bin
);

  import ddft_pkg::*;

  localparam int SAW    = $clog2(POINTS);
  localparam int STRIDE = ROM_SIZE / POINTS;
  localparam int SHIFT  = SAW + FRAC_W;
  localparam logic [BIN_W-1:0] LAST_IDX = BIN_W'(POINTS - 1);
  localparam logic signed [ACC_W-1:0] BIAS = ACC_W'((64'd1 << SHIFT) - 64'd1);
  localparam int PROD_W = 2 * SAMPLE_W;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_CALC  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [BIN_W-1:0] load_cnt_r, load_cnt_nxt;
  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic [BIN_W-1:0] n_r, n_nxt;
  logic [ROM_W-1:0] phase_r, phase_nxt;
  logic             v1_r, v1_nxt;
  logic             v2_r;
  logic             clr_acc;

  logic signed [SAMPLE_W-1:0] cos_r, sin_r;
  logic signed [PROD_W-1:0]   prod_c_r, prod_s_r;
  logic signed [ACC_W-1:0]    acc_c_r, acc_s_r;
  logic signed [SAMPLE_W-1:0] real_r, imag_r;
  logic signed [ACC_W-1:0]    q_c, q_s;

  logic                       in_xfer;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SAMPLE_W-1:0] sample_rd;
  logic [ROM_W-1:0]           phase_step;

  assign in_xfer    = in_valid && !in_stall;
  assign in_stall   = (state_r != ST_LOAD);
  assign phase_step = ROM_W'(bin_r * STRIDE);
  assign sample_rd  = $signed(ram_rdata);

  ddft_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(POINTS)
  ) u_store (
    .clk  (clk),
    .we   (in_xfer),
    .waddr(load_cnt_r[SAW-1:0]),
    .wdata(in_sample),
    .raddr(n_r[SAW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    bin_nxt      = bin_r;
    n_nxt        = n_r;
    phase_nxt    = phase_r;
    v1_nxt       = 1'b0;
    clr_acc      = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (load_cnt_r == LAST_IDX) begin
            load_cnt_nxt = '0;
            bin_nxt      = '0;
            n_nxt        = '0;
            phase_nxt    = '0;
            clr_acc      = 1'b1;
            state_nxt    = ST_CALC;
          end else begin
            load_cnt_nxt = load_cnt_r + 1'b1;
          end
        end
      end
      ST_CALC: begin
        v1_nxt    = 1'b1;
        phase_nxt = phase_r + phase_step;
        n_nxt     = n_r + 1'b1;
        if (n_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (bin_r == LAST_IDX) begin
            bin_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            bin_nxt   = bin_r + 1'b1;
            n_nxt     = '0;
            phase_nxt = '0;
            clr_acc   = 1'b1;
            state_nxt = ST_CALC;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_cnt_r <= '0;
      bin_r      <= '0;
      n_r        <= '0;
      phase_r    <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      acc_c_r    <= '0;
      acc_s_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      bin_r      <= bin_nxt;
      n_r        <= n_nxt;
      phase_r    <= phase_nxt;
      v1_r       <= v1_nxt;
      v2_r       <= v1_r;
      if (clr_acc) begin
        acc_c_r <= '0;
        acc_s_r <= '0;
      end else if (v2_r) begin
        acc_c_r <= acc_c_r + ACC_W'(prod_c_r);
        acc_s_r <= acc_s_r + ACC_W'(prod_s_r);
      end
    end
  end

  // Twiddles are fetched alongside the RAM read so both arrive together.
  always_ff @(posedge clk) begin
    cos_r    <= COS_TABLE[phase_r];
    sin_r    <= COS_TABLE[phase_r + SIN_OFFSET];
    prod_c_r <= sample_rd * cos_r;
    prod_s_r <= sample_rd * sin_r;
  end

  // Division by POINTS * 32768 truncated toward zero.
  assign q_c = (acc_c_r + (acc_c_r[ACC_W-1] ? BIAS : '0)) >>> SHIFT;
  assign q_s = (acc_s_r + (acc_s_r[ACC_W-1] ? BIAS : '0)) >>> SHIFT;

  always_ff @(posedge clk) begin
    if (state_r == ST_DRAIN) begin
      real_r <= q_c[SAMPLE_W-1:0];
      imag_r <= -q_s[SAMPLE_W-1:0];
    end
  end

  assign out_valid     = (state_r == ST_OUT);
  assign out_bin_index = bin_r;
  assign out_real_part = real_r;
  assign out_imag_part = imag_r;
  assign out_last_bin  = (bin_r == LAST_IDX);

endmodule
